/* sv/mfph_pkg.sv */
package mfph_pkg;

  // Fixed field widths
  localparam int PT_W     = 16;
  localparam int LEN_W    = 40;
  localparam int MARGIN_W = 10;
  localparam int TWO_PI_W = 51;

  // Saturation ceiling for all lengths
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // 2*pi with 48 fraction bits
  localparam logic [TWO_PI_W-1:0] TWO_PI_Q48 = 51'h6487ED5110B46;

  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic                   is_last;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] total_length;
    logic             overflow;
  } out_item_t;

endpackage

/* sv/mfph_ram.sv */
module mfph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/min_fence_partition_hull_unit.sv */
// Points are taken one per cycle while idle; a point without the last mark has no result.
// After the last point: the margin is scaled by 2*pi, then per subset a lower and an upper hull
//   pass and a perimeter sum with a serial square root per edge (RW = 34 root bits by default),
//   then the partition search over submasks; shared multiplier, serial root.
// One point set is worked on at a time; in_stall stays high until the result is registered.
// Synchronous active-low reset clears the sequencer, point count, drop flag, output valid and margin.
module min_fence_partition_hull_unit #(
  parameter int MAX_POINTS = 9,
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mfph_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mfph_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mfph_pkg::MARGIN_W-1:0]       cfg_data
);

  import mfph_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int MAXP = MAX_POINTS;
  localparam int CW   = $clog2(MAXP + 1);
  localparam int IW   = (MAXP > 1) ? $clog2(MAXP) : 1;
  localparam int NSUB = 1 << MAXP;
  localparam int SD   = 2 * MAXP + 2;
  localparam int SW   = $clog2(SD + 1);
  localparam int SIW  = $clog2(SD);
  localparam int DW   = CB + 1;
  localparam int PW   = 2 * DW;
  localparam int XW0  = PW + 1 + 2 * FRAC_BITS;
  localparam int RW   = (XW0 + 1) / 2;
  localparam int RW1  = RW + 1;
  localparam int XW   = 2 * RW;
  localparam int RMW  = RW + 3;
  localparam int RCW  = $clog2(RW + 1);
  localparam int SAW  = (RW1 > LEN_W) ? RW1 : LEN_W;
  localparam int SAW1 = SAW + 1;
  localparam int MW   = MARGIN_W + TWO_PI_W;
  localparam int MSH  = 48 - FRAC_BITS;
  localparam int MBW  = $clog2(MARGIN_W);

  typedef enum logic [4:0] {
    S_IDLE, S_MARG, S_MRND, S_HSCAN, S_HCHK, S_HRDB, S_X1, S_X2, S_HNEXT,
    S_FIX, S_ELA, S_ELB, S_SQ1, S_SQ2, S_ROOT, S_RND, S_GW,
    S_DINIT, S_DRD, S_DCMP, S_DWR, S_ORD, S_OWT
  } state_t;

  // Saturating add into the length range
  function automatic logic [LEN_W-1:0] sat_add(input logic [SAW-1:0] a,
                                               input logic [SAW-1:0] b);
    logic [SAW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > SAW1'(LEN_MAX)) ? LEN_MAX : s[LEN_W-1:0];
  endfunction

  state_t state_r;

  logic [MARGIN_W-1:0] margin_r;
  logic [CW-1:0]       cnt_r;
  logic                drop_r;
  logic [CW-1:0]       n_r;
  logic [MAXP-1:0]     full_r;
  logic                ovf_r;

  // Points kept sorted by x then y, with their arrival index
  logic signed [CB-1:0] sx_r [MAXP];
  logic signed [CB-1:0] sy_r [MAXP];
  logic [IW-1:0]        sid_r [MAXP];

  // Margin accumulation
  logic [MW-1:0]    macc_r;
  logic [MBW-1:0]   mb_r;
  logic [LEN_W-1:0] marg_r;

  // Hull builder
  logic [MAXP-1:0]      mask_r;
  logic                 pass_r;
  logic [IW-1:0]        j_r;
  logic [SW-1:0]        hs_r;
  logic [SW-1:0]        start_r;
  logic [SW-1:0]        ek_r;
  logic signed [CB-1:0] hx_r [SD];
  logic signed [CB-1:0] hy_r [SD];
  logic signed [CB-1:0] ax_r, ay_r, bx_r, by_r, qx_r, qy_r;
  logic signed [PW-1:0] p1_r;
  logic [LEN_W-1:0]     sum_r;

  // Square root
  logic [XW-1:0]  x_r;
  logic [RMW-1:0] rem_r;
  logic [RW-1:0]  root_r;
  logic [RCW-1:0] rc_r;

  // Partition search
  logic [MAXP-1:0]  i_r;
  logic [MAXP-1:0]  k_r;
  logic [LEN_W-1:0] best_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  // Cost memories
  logic             grp_we, bst_we, grp_re, bst_re;
  logic [MAXP-1:0]  bst_waddr, bst_raddr;
  logic [LEN_W-1:0] grp_wdata, bst_wdata, grp_rdata, bst_rdata;

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sorted insertion of an arriving point: each entry looks at itself and its neighbor
  logic signed [CB-1:0] nx, ny;
  logic [MAXP-1:0]      gt, gtp;
  logic signed [CB-1:0] sxp [MAXP];
  logic signed [CB-1:0] syp [MAXP];
  logic [IW-1:0]        sidp [MAXP];
  logic signed [CB-1:0] sx_ins [MAXP];
  logic signed [CB-1:0] sy_ins [MAXP];
  logic [IW-1:0]        sid_ins [MAXP];
  logic [CW-1:0]        n_here;
  logic [MAXP-1:0]      full_ins;

  always_comb begin
    nx = in_data.point_x[CB-1:0];
    ny = in_data.point_y[CB-1:0];
    for (int e = 0; e < MAXP; e++) begin
      gt[e] = (CW'(e) < cnt_r) &&
              ((sx_r[e] > nx) || ((sx_r[e] == nx) && (sy_r[e] > ny)));
    end
    gtp = gt << 1;
    sxp[0]  = nx;
    syp[0]  = ny;
    sidp[0] = cnt_r[IW-1:0];
    for (int e = 1; e < MAXP; e++) begin
      sxp[e]  = sx_r[e-1];
      syp[e]  = sy_r[e-1];
      sidp[e] = sid_r[e-1];
    end
    for (int e = 0; e < MAXP; e++) begin
      if ((CW'(e) < cnt_r) && !gt[e]) begin
        sx_ins[e]  = sx_r[e];
        sy_ins[e]  = sy_r[e];
        sid_ins[e] = sid_r[e];
      end else if (gtp[e]) begin
        sx_ins[e]  = sxp[e];
        sy_ins[e]  = syp[e];
        sid_ins[e] = sidp[e];
      end else begin
        sx_ins[e]  = nx;
        sy_ins[e]  = ny;
        sid_ins[e] = cnt_r[IW-1:0];
      end
    end
    n_here = (cnt_r != CW'(MAXP)) ? cnt_r + CW'(1) : cnt_r;
    for (int b = 0; b < MAXP; b++) begin
      full_ins[b] = (CW'(b) < n_here);
    end
  end

  // Shared multiplier: cross-product terms and squared edge components
  logic signed [DW-1:0] dbx, dby, dqx, dqy, ma, mb;
  logic signed [PW-1:0] mul_p;
  logic signed [PW:0]   crs;
  logic                 crs_le0;
  logic [PW:0]          d2;

  assign dbx = {bx_r[CB-1], bx_r} - {ax_r[CB-1], ax_r};
  assign dby = {by_r[CB-1], by_r} - {ay_r[CB-1], ay_r};
  assign dqx = {qx_r[CB-1], qx_r} - {ax_r[CB-1], ax_r};
  assign dqy = {qy_r[CB-1], qy_r} - {ay_r[CB-1], ay_r};

  always_comb begin
    unique case (state_r)
      S_X1: begin
        ma = dbx;
        mb = dqy;
      end
      S_X2: begin
        ma = dby;
        mb = dqx;
      end
      S_SQ1: begin
        ma = dbx;
        mb = dbx;
      end
      default: begin
        ma = dby;
        mb = dby;
      end
    endcase
  end

  assign mul_p   = ma * mb;
  assign crs     = {p1_r[PW-1], p1_r} - {mul_p[PW-1], mul_p};
  assign crs_le0 = crs[PW] || (crs == '0);
  assign d2      = {1'b0, p1_r} + {1'b0, mul_p};

  // Square root digit step
  logic [RMW-1:0] remsh, trial;
  logic           take;
  logic [RW:0]    rup;

  assign remsh = {rem_r[RMW-3:0], x_r[XW-1:XW-2]};
  assign trial = RMW'({root_r, 2'b01});
  assign take  = (remsh >= trial);
  assign rup   = {1'b0, root_r} + RW1'(rem_r > RMW'(root_r));

  // Stack addressing
  logic [SW-1:0]  hs_m1, hs_m2, ek_p1;
  logic [SIW-1:0] eb_idx;
  logic [CW-1:0]  nm1;
  logic [IW-1:0]  jlast;
  logic           at_end;
  logic [SW-1:0]  hs_end;
  logic [MW-1:0]  mfull;
  logic [LEN_W-1:0] dp_c;

  assign hs_m1  = hs_r - SW'(1);
  assign hs_m2  = hs_r - SW'(2);
  assign ek_p1  = ek_r + SW'(1);
  assign eb_idx = (ek_p1 == hs_r) ? '0 : ek_p1[SIW-1:0];
  assign nm1    = n_r - CW'(1);
  assign jlast  = nm1[IW-1:0];
  assign at_end = pass_r ? (j_r == '0) : (j_r == jlast);
  assign hs_end = (hs_r == '0) ? hs_r : hs_m1;
  assign mfull  = macc_r + (MW'(1) << (MSH - 1));
  assign dp_c   = sat_add(SAW'(bst_rdata), SAW'(grp_rdata));

  // Memory control
  assign grp_we    = (state_r == S_GW);
  assign grp_wdata = sat_add(SAW'(sum_r), SAW'(marg_r));
  assign grp_re    = (state_r == S_DRD);
  assign bst_we    = (state_r == S_DINIT) || (state_r == S_DWR);
  assign bst_waddr = (state_r == S_DWR) ? i_r : '0;
  assign bst_wdata = (state_r == S_DWR) ? best_r : '0;
  assign bst_re    = (state_r == S_DRD) || (state_r == S_ORD);
  assign bst_raddr = (state_r == S_ORD) ? full_r : k_r;

  mfph_ram #(.WIDTH(LEN_W), .DEPTH(NSUB)) u_grp_ram (
    .clk   (clk),
    .we    (grp_we),
    .waddr (mask_r),
    .wdata (grp_wdata),
    .re    (grp_re),
    .raddr (i_r ^ k_r),
    .rdata (grp_rdata)
  );

  mfph_ram #(.WIDTH(LEN_W), .DEPTH(NSUB)) u_bst_ram (
    .clk   (clk),
    .we    (bst_we),
    .waddr (bst_waddr),
    .wdata (bst_wdata),
    .re    (bst_re),
    .raddr (bst_raddr),
    .rdata (bst_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      margin_r    <= '0;
    end else begin
      if (cfg_valid) begin
        margin_r <= cfg_data;
      end
      if (out_valid_r && !out_stall && (state_r != S_OWT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (cnt_r != CW'(MAXP)) begin
              sx_r  <= sx_ins;
              sy_r  <= sy_ins;
              sid_r <= sid_ins;
            end
            if (in_data.is_last) begin
              n_r     <= n_here;
              full_r  <= full_ins;
              ovf_r   <= drop_r || (cnt_r == CW'(MAXP));
              cnt_r   <= '0;
              drop_r  <= 1'b0;
              macc_r  <= '0;
              mb_r    <= MBW'(MARGIN_W - 1);
              state_r <= S_MARG;
            end else begin
              cnt_r  <= n_here;
              drop_r <= drop_r || (cnt_r == CW'(MAXP));
            end
          end
        end
        // margin * 2pi, one bit per cycle
        S_MARG: begin
          macc_r <= {macc_r[MW-2:0], 1'b0} +
                    (margin_r[mb_r] ? MW'(TWO_PI_Q48) : '0);
          mb_r   <= mb_r - MBW'(1);
          if (mb_r == '0) begin
            state_r <= S_MRND;
          end
        end
        S_MRND: begin
          marg_r  <= LEN_W'(mfull >> MSH);
          mask_r  <= MAXP'(1);
          hs_r    <= '0;
          start_r <= '0;
          pass_r  <= 1'b0;
          j_r     <= '0;
          state_r <= S_HSCAN;
        end
        // Monotone chain over the sorted points that are in the subset
        S_HSCAN: begin
          if (mask_r[sid_r[j_r]]) begin
            qx_r    <= sx_r[j_r];
            qy_r    <= sy_r[j_r];
            state_r <= S_HCHK;
          end else begin
            state_r <= S_HNEXT;
          end
        end
        S_HCHK: begin
          if (hs_r >= start_r + SW'(2)) begin
            ax_r    <= hx_r[hs_m2[SIW-1:0]];
            ay_r    <= hy_r[hs_m2[SIW-1:0]];
            state_r <= S_HRDB;
          end else begin
            hx_r[hs_r[SIW-1:0]] <= qx_r;
            hy_r[hs_r[SIW-1:0]] <= qy_r;
            hs_r    <= hs_r + SW'(1);
            state_r <= S_HNEXT;
          end
        end
        S_HRDB: begin
          bx_r    <= hx_r[hs_m1[SIW-1:0]];
          by_r    <= hy_r[hs_m1[SIW-1:0]];
          state_r <= S_X1;
        end
        S_X1: begin
          p1_r    <= mul_p;
          state_r <= S_X2;
        end
        S_X2: begin
          if (crs_le0) begin
            hs_r    <= hs_m1;
            state_r <= S_HCHK;
          end else begin
            hx_r[hs_r[SIW-1:0]] <= qx_r;
            hy_r[hs_r[SIW-1:0]] <= qy_r;
            hs_r    <= hs_r + SW'(1);
            state_r <= S_HNEXT;
          end
        end
        S_HNEXT: begin
          if (!at_end) begin
            j_r     <= pass_r ? j_r - IW'(1) : j_r + IW'(1);
            state_r <= S_HSCAN;
          end else begin
            hs_r <= hs_end;
            if (!pass_r) begin
              pass_r  <= 1'b1;
              start_r <= hs_end;
              j_r     <= jlast;
              state_r <= S_HSCAN;
            end else begin
              state_r <= S_FIX;
            end
          end
        end
        // Two equal points collapse to one
        S_FIX: begin
          if (hs_r == SW'(2) && hx_r[0] == hx_r[1] && hy_r[0] == hy_r[1]) begin
            hs_r <= SW'(1);
          end
          ek_r  <= '0;
          sum_r <= '0;
          state_r <= (hs_r == '0) ? S_GW : S_ELA;
        end
        // Perimeter, one edge at a time
        S_ELA: begin
          ax_r    <= hx_r[ek_r[SIW-1:0]];
          ay_r    <= hy_r[ek_r[SIW-1:0]];
          state_r <= S_ELB;
        end
        S_ELB: begin
          bx_r    <= hx_r[eb_idx];
          by_r    <= hy_r[eb_idx];
          state_r <= S_SQ1;
        end
        S_SQ1: begin
          p1_r    <= mul_p;
          state_r <= S_SQ2;
        end
        S_SQ2: begin
          x_r     <= XW'({d2, {(2 * FRAC_BITS){1'b0}}});
          rem_r   <= '0;
          root_r  <= '0;
          rc_r    <= RCW'(RW);
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          x_r    <= {x_r[XW-3:0], 2'b00};
          rem_r  <= take ? remsh - trial : remsh;
          root_r <= {root_r[RW-2:0], take};
          rc_r   <= rc_r - RCW'(1);
          if (rc_r == RCW'(1)) begin
            state_r <= S_RND;
          end
        end
        S_RND: begin
          sum_r   <= sat_add(SAW'(sum_r), SAW'(rup));
          ek_r    <= ek_p1;
          state_r <= (ek_p1 == hs_r) ? S_GW : S_ELA;
        end
        S_GW: begin
          if (mask_r == full_r) begin
            state_r <= S_DINIT;
          end else begin
            mask_r  <= mask_r + MAXP'(1);
            hs_r    <= '0;
            start_r <= '0;
            pass_r  <= 1'b0;
            j_r     <= '0;
            state_r <= S_HSCAN;
          end
        end
        // Best partition over submasks
        S_DINIT: begin
          i_r     <= MAXP'(1);
          k_r     <= '0;
          best_r  <= LEN_MAX;
          state_r <= S_DRD;
        end
        S_DRD: begin
          state_r <= S_DCMP;
        end
        S_DCMP: begin
          if (dp_c < best_r) begin
            best_r <= dp_c;
          end
          if (k_r == '0) begin
            state_r <= S_DWR;
          end else begin
            k_r     <= (k_r - MAXP'(1)) & i_r;
            state_r <= S_DRD;
          end
        end
        S_DWR: begin
          if (i_r == full_r) begin
            state_r <= S_ORD;
          end else begin
            i_r     <= i_r + MAXP'(1);
            k_r     <= i_r & (i_r + MAXP'(1));
            best_r  <= LEN_MAX;
            state_r <= S_DRD;
          end
        end
        S_ORD: begin
          state_r <= S_OWT;
        end
        S_OWT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.total_length <= bst_rdata;
            out_data_r.overflow     <= ovf_r;
            out_valid_r             <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Hull stack never runs past its storage
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HCHK) |-> (hs_r < SW'(SD)))
    else $error("hull stack overflow");

  // Partition split is always a submask of the current set
  a_submask: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DCMP) |-> ((k_r & ~i_r) == '0))
    else $error("split is not a submask");

  // A group never costs less than its margin
  a_group_margin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GW) |-> (grp_wdata >= marg_r))
    else $error("group cost below margin");

endmodule

/* bench/min_fence_partition_hull_unit_test.sv */
module min_fence_partition_hull_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mfph_pkg::*;

  localparam int NPTS        = 9;
  localparam int SETTLE      = 40;
  localparam int WATCH_LIMIT = 3000000;

  typedef enum logic [1:0] {JOB_POINT, JOB_MARGIN, JOB_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t                 kind;
    in_item_t                  pt;
    logic [MARGIN_W-1:0]       margin;
    int                        gap;
  } job_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [MARGIN_W-1:0]   cfg_data = '0;

  job_t                  jobs[$];
  out_item_t             fence_due_q[$];
  int                    errors = 0;
  int                    idle_cycles = 0;
  bit                    burst_in = 1'b0;

  // predictor state
  longint                pt_x[NPTS];
  longint                pt_y[NPTS];
  int                    pt_count = 0;
  bit                    pt_dropped = 1'b0;
  logic [MARGIN_W-1:0]   margin_model = '0;

  always #4 clk = ~clk;

  min_fence_partition_hull_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // saturating add at 40 bits
  function automatic logic [63:0] len_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > 64'(LEN_MAX)) ? 64'(LEN_MAX) : s;
  endfunction

  // round(sqrt(d2) * 2^16), ties up
  function automatic logic [63:0] root_round(logic [63:0] d2);
    logic [127:0] x;
    logic [127:0] cand;
    logic [127:0] r;
    x = {64'd0, d2} << 32;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      cand = r | (128'd1 << b);
      if (cand * cand <= x) r = cand;
    end
    if (x > r * r + r) r = r + 1;
    return r[63:0];
  endfunction

  function automatic longint turn(longint ax, longint ay, longint bx, longint by,
                                  longint cx, longint cy);
    return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
  endfunction

  // hull perimeter of one group plus its margin
  function automatic logic [63:0] group_len(int mask, int n);
    longint sx[NPTS];
    longint sy[NPTS];
    longint hx[2*NPTS+2];
    longint hy[2*NPTS+2];
    longint vx, vy, qx, qy, dx, dy;
    int cnt, hs, j, start;
    logic [63:0] sum, marg;
    cnt = 0;
    hs = 0;
    sum = 0;
    for (int i = 0; i < n; i++)
      if (mask[i]) begin
        sx[cnt] = pt_x[i];
        sy[cnt] = pt_y[i];
        cnt++;
      end
    // sort by x then y
    for (int i = 1; i < cnt; i++) begin
      vx = sx[i];
      vy = sy[i];
      j = i;
      while (j > 0 && (sx[j-1] > vx || (sx[j-1] == vx && sy[j-1] > vy))) begin
        sx[j] = sx[j-1];
        sy[j] = sy[j-1];
        j--;
      end
      sx[j] = vx;
      sy[j] = vy;
    end
    // monotone chain, lower then upper
    for (int pass = 0; pass < 2; pass++) begin
      start = hs;
      for (int k = 0; k < cnt; k++) begin
        qx = pass ? sx[cnt-1-k] : sx[k];
        qy = pass ? sy[cnt-1-k] : sy[k];
        while (hs >= start + 2 &&
               turn(hx[hs-2], hy[hs-2], hx[hs-1], hy[hs-1], qx, qy) <= 0) hs--;
        hx[hs] = qx;
        hy[hs] = qy;
        hs++;
      end
      if (hs > 0) hs--;
    end
    if (hs == 2 && hx[0] == hx[1] && hy[0] == hy[1]) hs = 1;
    for (int k = 0; k < hs; k++) begin
      dx = hx[k] - hx[(k+1) % hs];
      dy = hy[k] - hy[(k+1) % hs];
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sum = len_add(sum, root_round(64'(dx * dx + dy * dy)));
    end
    marg = (64'(margin_model) * 64'(TWO_PI_Q48) + (64'd1 << 31)) >> 32;
    return len_add(sum, marg);
  endfunction

  // least total fence over all partitions of the stored points
  function automatic out_item_t min_fence_length();
    logic [63:0] grp[1<<NPTS];
    logic [63:0] best[1<<NPTS];
    logic [63:0] low, c;
    int full, k;
    out_item_t res;
    full = (1 << pt_count) - 1;
    for (int i = 1; i <= full; i++) grp[i] = group_len(i, pt_count);
    best[0] = 0;
    for (int i = 1; i <= full; i++) begin
      low = 64'(LEN_MAX);
      k = (i - 1) & i;
      forever begin
        c = len_add(best[k], grp[i ^ k]);
        if (c < low) low = c;
        if (k == 0) break;
        k = (k - 1) & i;
      end
      best[i] = low;
    end
    res.total_length = best[full][LEN_W-1:0];
    res.overflow = pt_dropped;
    return res;
  endfunction

  // take in one point; a closing point yields an expected result
  task automatic take_point(in_item_t p);
    if (pt_count < NPTS) begin
      pt_x[pt_count] = longint'($signed(p.point_x));
      pt_y[pt_count] = longint'($signed(p.point_y));
      pt_count++;
    end else begin
      pt_dropped = 1'b1;
    end
    if (p.is_last) begin
      fence_due_q.push_back(min_fence_length());
      pt_count = 0;
      pt_dropped = 1'b0;
    end
  endtask

  // driver: points and margin writes from the job queue
  int waited = 0;
  always @(posedge clk) begin : driver
    logic nv, ncv;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      waited = 0;
    end else begin
      nv = in_valid;
      ncv = cfg_valid;
      if (in_valid && !in_stall) begin
        take_point(in_data);
        nv = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        margin_model = cfg_data;
        ncv = 1'b0;
      end
      if (!nv && !ncv && jobs.size() > 0) begin
        if (jobs[0].kind == JOB_POINT) begin
          if (waited < jobs[0].gap) begin
            waited++;
          end else begin
            in_data <= jobs[0].pt;
            nv = 1'b1;
            void'(jobs.pop_front());
            waited = 0;
          end
        end else if (fence_due_q.size() != 0) begin
          waited = 0;
        end else if (waited < SETTLE) begin
          waited++;
        end else begin
          if (jobs[0].kind == JOB_MARGIN) begin
            cfg_data <= jobs[0].margin;
            ncv = 1'b1;
          end
          void'(jobs.pop_front());
          waited = 0;
        end
      end
      in_valid <= nv;
      cfg_valid <= ncv;
    end
  end

  // monitor: random stall, compare each result with the oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (fence_due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual len=%0h ovf=%0b",
                 $time, out_data.total_length, out_data.overflow);
      end else begin
        want = fence_due_q.pop_front();
        if (out_data.total_length !== want.total_length) begin
          errors++;
          $display("%0t: total_length mismatch: expected %0h, actual %0h",
                   $time, want.total_length, out_data.total_length);
        end
        if (out_data.overflow !== want.overflow) begin
          errors++;
          $display("%0t: overflow mismatch: expected %0b, actual %0b",
                   $time, want.overflow, out_data.overflow);
        end
      end
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_point(int x, int y, bit last);
    job_t j;
    j.kind = JOB_POINT;
    j.pt.point_x = x[15:0];
    j.pt.point_y = y[15:0];
    j.pt.is_last = last;
    j.margin = '0;
    j.gap = burst_in ? 0 : $urandom_range(0, 15);
    jobs.push_back(j);
  endtask

  task automatic add_ctrl(job_kind_t kind, logic [MARGIN_W-1:0] m);
    job_t j;
    j.kind = kind;
    j.pt = '0;
    j.margin = m;
    j.gap = 0;
    jobs.push_back(j);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return int'($signed(16'($urandom)));
      3: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: return int'($urandom_range(0, 32)) - 16;
    endcase
  endfunction

  // one random point set of n points
  task automatic add_set(int n);
    burst_in = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) add_point(rand_coord(), rand_coord(), i == n - 1);
  endtask

  int items;
  initial begin
    // directed: margin zero from reset
    add_point(5, -7, 1);                               // single point
    add_point(3, 3, 0); add_point(3, 3, 1);            // two equal points
    add_point(0, 0, 0); add_point(3, 4, 1);            // two distinct points
    add_point(0, 0, 0); add_point(2, 2, 0); add_point(4, 4, 1);  // collinear
    add_point(-32768, -32768, 0); add_point(32767, 32767, 0);
    add_point(-32768, 32767, 0); add_point(32767, -32768, 1);
    add_ctrl(JOB_MARGIN, 10'd1023);
    add_point(0, 0, 0); add_point(1, 0, 0); add_point(0, 1, 0); add_point(1, 1, 1);
    add_ctrl(JOB_MARGIN, 10'd0);
    // too many points: last two are dropped
    for (int i = 0; i < 11; i++) add_point(i * 7 - 30, (i * i) % 13 - 6, i == 10);
    add_ctrl(JOB_MARGIN, 10'd1);
    items = 27;
    // random sets, mostly small
    for (int s = 0; items < 290; s++) begin
      int n;
      if (s % 12 == 11)
        add_ctrl(JOB_MARGIN, ($urandom_range(0, 2) == 0) ? 10'd1023 : 10'($urandom));
      if (s == 20) add_ctrl(JOB_DRAIN, '0);
      n = (s == 40) ? NPTS : $urandom_range(1, 6);
      add_set(n);
      items += n;
    end
    add_ctrl(JOB_MARGIN, 10'd0);
    add_set(3);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (jobs.size() != 0 || in_valid || cfg_valid || fence_due_q.size() != 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/mfph_pkg.sv
sv/mfph_ram.sv
sv/min_fence_partition_hull_unit.sv
bench/min_fence_partition_hull_unit_test.sv
